// ----- design/osw_pkg.sv -----
// package for the obstacle sense and wheel trim block
// types, constants and codes shared by the interfaces and all modules; no dependencies
package osw_pkg;

	localparam int SAMPLE_BITS  = 12;
	localparam int ENCODER_BITS = 32;
	localparam int CHANNELS     = 5;
	localparam int THRESH_BITS  = 12;
	localparam int CMP_BITS     = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;
	localparam int DEBOUNCE_BITS = 3;
	localparam int COUNT_BITS   = DEBOUNCE_BITS + 1;
	localparam int DELTA_BITS   = 8;
	localparam int LEVEL_BITS   = 5;
	localparam int PERIOD_BITS  = 8;
	localparam int DEAD_BAND    = 1;
	localparam int CFG_IDX_BITS = 2;

	// channel positions
	localparam int CH_L  = 0;
	localparam int CH_CL = 1;
	localparam int CH_C  = 2;
	localparam int CH_CR = 3;
	localparam int CH_R  = 4;

	// reset values of the configuration registers
	localparam logic [THRESH_BITS-1:0]   THRESHOLD_RST = THRESH_BITS'(150);
	localparam logic [DEBOUNCE_BITS-1:0] DEBOUNCE_RST  = DEBOUNCE_BITS'(3);
	localparam logic [DELTA_BITS-1:0]    CRUISE_RST    = DELTA_BITS'(10);
	localparam logic [LEVEL_BITS-1:0]    START_RST     = LEVEL_BITS'(15);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_CHANGE_THRESHOLD = 2'd0,
		CFG_DEBOUNCE_COUNT   = 2'd1,
		CFG_CRUISE_DELTA     = 2'd2,
		CFG_START_LEVEL      = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		COND_OK    = 3'd0,
		COND_BOTH  = 3'd1,
		COND_LEFT  = 3'd2,
		COND_RIGHT = 3'd3,
		COND_HEAD  = 3'd4
	} cond_t;

	typedef enum logic [1:0] {
		AVOID_NONE  = 2'd0,
		AVOID_LEFT  = 2'd1,
		AVOID_RIGHT = 2'd2
	} avoid_t;

	typedef enum logic [1:0] {
		ADJ_HOLD = 2'd0,
		ADJ_DEC  = 2'd1,
		ADJ_INC  = 2'd2
	} adjust_t;

	typedef struct packed {
		logic [SAMPLE_BITS-1:0]  ir_left;
		logic [SAMPLE_BITS-1:0]  ir_center_left;
		logic [SAMPLE_BITS-1:0]  ir_center;
		logic [SAMPLE_BITS-1:0]  ir_center_right;
		logic [SAMPLE_BITS-1:0]  ir_right;
		logic [1:0]              bumper_n;
		logic [ENCODER_BITS-1:0] left_encoder;
		logic [ENCODER_BITS-1:0] right_encoder;
		logic [LEVEL_BITS-1:0]   left_level;
		logic [LEVEL_BITS-1:0]   right_level;
		logic                    avoid_busy;
		logic                    trim_busy;
	} tick_t;

	typedef struct packed {
		cond_t   path_condition;
		avoid_t  avoid_command;
		logic    left_start;
		logic    right_start;
		adjust_t left_adjust;
		adjust_t right_adjust;
	} result_t;

	typedef struct packed {
		logic [THRESH_BITS-1:0]   change_threshold;
		logic [DEBOUNCE_BITS-1:0] debounce_count;
		logic [DELTA_BITS-1:0]    cruise_delta;
		logic [LEVEL_BITS-1:0]    start_level;
	} cfg_t;

endpackage

// ----- design/osw_if.sv -----
// channel interfaces of the obstacle sense and wheel trim block
// depends on osw_pkg for the payload types
interface osw_tick_if;
	logic           valid;
	logic           ready;
	osw_pkg::tick_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface osw_result_if;
	logic             valid;
	logic             ready;
	osw_pkg::result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface osw_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [osw_pkg::CFG_IDX_BITS-1:0]   index;
	logic [osw_pkg::THRESH_BITS-1:0]    wdata;

	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

// ----- design/obstacle_sense_and_wheel_trim.sv -----
// top level of the obstacle sense and wheel trim block
// depends on osw_pkg, osw_if, osw_ir_chan and osw_ctrl
//
//  channel  dir  payload                         transaction
//  tick     in   tick_t (ir levels, encoders..)   valid & ready
//  result   out  result_t (condition, commands)   valid & ready
//  cfg      in   index, wdata                     valid & ready, always ready
//
// one tick per cycle sustained unless the result stalls; a tick is registered at
// acceptance, evaluated in the next cycle and then moves into the result register.
// reset clears the sample history, counters, latched encoders and the
// configuration to its defaults. a stalled result holds the result register;
// a new tick is still taken while the input stage can move on.
module obstacle_sense_and_wheel_trim (
	input  logic        clk,
	input  logic        arst_n,
	osw_tick_if.sink    tick,
	osw_result_if.source result,
	osw_cfg_if.sink     cfg
);

	logic             valid_s1;
	osw_pkg::tick_t   tick_s1;
	logic             res_valid_q;
	osw_pkg::result_t res_q;
	osw_pkg::cfg_t    cfg_q;
	osw_pkg::result_t res_next;
	logic [osw_pkg::CHANNELS-1:0] act;
	logic [osw_pkg::SAMPLE_BITS-1:0] samples [osw_pkg::CHANNELS];
	logic             adv;
	logic             accept;

	assign adv        = valid_s1 && (!res_valid_q || result.ready);
	assign tick.ready = !valid_s1 || adv;
	assign accept     = tick.valid && tick.ready;
	assign cfg.ready  = 1'b1;
	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	assign samples[osw_pkg::CH_L]  = tick_s1.ir_left;
	assign samples[osw_pkg::CH_CL] = tick_s1.ir_center_left;
	assign samples[osw_pkg::CH_C]  = tick_s1.ir_center;
	assign samples[osw_pkg::CH_CR] = tick_s1.ir_center_right;
	assign samples[osw_pkg::CH_R]  = tick_s1.ir_right;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.change_threshold <= osw_pkg::THRESHOLD_RST;
			cfg_q.debounce_count   <= osw_pkg::DEBOUNCE_RST;
			cfg_q.cruise_delta     <= osw_pkg::CRUISE_RST;
			cfg_q.start_level      <= osw_pkg::START_RST;
		end else if (cfg.valid) begin
			unique case (osw_pkg::cfg_idx_t'(cfg.index))
				osw_pkg::CFG_CHANGE_THRESHOLD:
					cfg_q.change_threshold <= cfg.wdata;
				osw_pkg::CFG_DEBOUNCE_COUNT:
					cfg_q.debounce_count <= cfg.wdata[osw_pkg::DEBOUNCE_BITS-1:0];
				osw_pkg::CFG_CRUISE_DELTA:
					cfg_q.cruise_delta <= cfg.wdata[osw_pkg::DELTA_BITS-1:0];
				osw_pkg::CFG_START_LEVEL:
					cfg_q.start_level <= cfg.wdata[osw_pkg::LEVEL_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv)
				res_valid_q <= 1'b1;
			else if (result.ready)
				res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			tick_s1 <= tick.data;
		if (adv)
			res_q <= res_next;
	end

	for (genvar i = 0; i < osw_pkg::CHANNELS; i++) begin : g_chan
		osw_ir_chan u_chan (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.sample (samples[i]),
			.cfg    (cfg_q),
			.active (act[i])
		);
	end

	osw_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.act    (act),
		.tick   (tick_s1),
		.cfg    (cfg_q),
		.res    (res_next)
	);

endmodule

// ----- design/osw_ir_chan.sv -----
// one infrared channel: previous sample and debounced activity counter
// depends on osw_pkg
module osw_ir_chan (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             en,
	input  logic [osw_pkg::SAMPLE_BITS-1:0]  sample,
	input  osw_pkg::cfg_t                    cfg,
	output logic                             active
);

	logic [osw_pkg::SAMPLE_BITS-1:0] prev_q;
	logic [osw_pkg::COUNT_BITS-1:0]  count_q;
	logic [osw_pkg::SAMPLE_BITS-1:0] diff;
	logic [osw_pkg::COUNT_BITS-1:0]  ceiling;
	logic [osw_pkg::COUNT_BITS-1:0]  count_next;
	logic                            changed;

	always_comb begin
		diff    = (sample > prev_q) ? sample - prev_q : prev_q - sample;
		changed = osw_pkg::CMP_BITS'(diff) > osw_pkg::CMP_BITS'(cfg.change_threshold);
		ceiling = {cfg.debounce_count, 1'b0};
		count_next = count_q;
		if (changed) begin
			if (count_q < ceiling)
				count_next = count_q + 1'b1;
		end else if (count_q != '0) begin
			count_next = count_q - 1'b1;
		end
		active = count_next >= osw_pkg::COUNT_BITS'(cfg.debounce_count);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			count_q <= '0;
		end else if (en) begin
			prev_q  <= sample;
			count_q <= count_next;
		end
	end

endmodule

// ----- design/osw_ctrl.sv -----
// path classification, avoid command, wheel start and speed trim
// depends on osw_pkg; takes the channel activity flags from osw_ir_chan
module osw_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic [osw_pkg::CHANNELS-1:0]  act,
	input  osw_pkg::tick_t                tick,
	input  osw_pkg::cfg_t                 cfg,
	output osw_pkg::result_t              res
);

	osw_pkg::cond_t                  held_q;
	logic [osw_pkg::PERIOD_BITS-1:0] period_q;
	logic [1:0]                      mod3_q;
	logic [osw_pkg::ENCODER_BITS-1:0] lat_l_q;
	logic [osw_pkg::ENCODER_BITS-1:0] lat_r_q;

	osw_pkg::cond_t                   cond_new;
	osw_pkg::avoid_t                  cmd_new;
	osw_pkg::cond_t                   held_next;
	logic [osw_pkg::ENCODER_BITS-1:0] lat_l_eff;
	logic [osw_pkg::ENCODER_BITS-1:0] lat_r_eff;
	logic [osw_pkg::ENCODER_BITS-1:0] lat_l_next;
	logic [osw_pkg::ENCODER_BITS-1:0] lat_r_next;
	logic [osw_pkg::PERIOD_BITS-1:0]  period_next;
	logic [1:0]                       mod3_inc;
	logic [1:0]                       mod3_next;
	logic                             bump_l;
	logic                             bump_r;
	logic                             check;
	logic                             lat_any;
	logic [osw_pkg::DELTA_BITS-1:0]   delta_l;
	logic [osw_pkg::DELTA_BITS-1:0]   delta_r;

	function automatic osw_pkg::adjust_t trim_of(input logic [osw_pkg::DELTA_BITS-1:0] delta,
			input logic [osw_pkg::DELTA_BITS-1:0] cruise);
		logic signed [osw_pkg::DELTA_BITS+1:0] d;
		logic signed [osw_pkg::DELTA_BITS+1:0] band;
		begin
			d    = signed'({2'b00, delta}) - signed'({2'b00, cruise});
			band = signed'((osw_pkg::DELTA_BITS+2)'(osw_pkg::DEAD_BAND));
			if (d > band)
				trim_of = osw_pkg::ADJ_DEC;
			else if (d < -band)
				trim_of = osw_pkg::ADJ_INC;
			else
				trim_of = osw_pkg::ADJ_HOLD;
		end
	endfunction

	always_comb begin
		bump_l = !tick.bumper_n[0];
		bump_r = !tick.bumper_n[1];
		priority if (act[osw_pkg::CH_R] && act[osw_pkg::CH_L]) begin
			cond_new = osw_pkg::COND_BOTH;
			cmd_new  = osw_pkg::AVOID_LEFT;
		end else if (act[osw_pkg::CH_L] || act[osw_pkg::CH_CL] || bump_l) begin
			cond_new = osw_pkg::COND_LEFT;
			cmd_new  = osw_pkg::AVOID_LEFT;
		end else if (act[osw_pkg::CH_R] || act[osw_pkg::CH_CR] || bump_r) begin
			cond_new = osw_pkg::COND_RIGHT;
			cmd_new  = osw_pkg::AVOID_RIGHT;
		end else if (act[osw_pkg::CH_C] || bump_l || bump_r) begin
			cond_new = osw_pkg::COND_HEAD;
			cmd_new  = osw_pkg::AVOID_LEFT;
		end else begin
			cond_new = osw_pkg::COND_OK;
			cmd_new  = osw_pkg::AVOID_NONE;
		end

		held_next = tick.avoid_busy ? held_q : cond_new;
		// any avoidance clears the latched counts before trim reads them
		if (!tick.avoid_busy && cmd_new != osw_pkg::AVOID_NONE) begin
			lat_l_eff = '0;
			lat_r_eff = '0;
		end else begin
			lat_l_eff = lat_l_q;
			lat_r_eff = lat_r_q;
		end

		// period counter residue mod 3, 255 wraps to 0
		if (period_q == '1)
			mod3_inc = 2'd0;
		else if (mod3_q == 2'd2)
			mod3_inc = 2'd0;
		else
			mod3_inc = mod3_q + 2'd1;

		check   = !tick.trim_busy && (mod3_inc == 2'd0);
		lat_any = (lat_l_eff != '0) || (lat_r_eff != '0);
		delta_l = tick.left_encoder[osw_pkg::DELTA_BITS-1:0]
			- lat_l_eff[osw_pkg::DELTA_BITS-1:0];
		delta_r = tick.right_encoder[osw_pkg::DELTA_BITS-1:0]
			- lat_r_eff[osw_pkg::DELTA_BITS-1:0];

		period_next = tick.trim_busy ? period_q : period_q + 1'b1;
		mod3_next   = tick.trim_busy ? mod3_q : mod3_inc;
		lat_l_next  = check ? tick.left_encoder : lat_l_eff;
		lat_r_next  = check ? tick.right_encoder : lat_r_eff;

		res.path_condition = held_next;
		res.avoid_command  = tick.avoid_busy ? osw_pkg::AVOID_NONE : cmd_new;
		res.left_start     = !tick.trim_busy && (tick.left_level == '0);
		res.right_start    = !tick.trim_busy && (tick.right_level == '0);
		res.left_adjust    = (check && lat_any) ? trim_of(delta_l, cfg.cruise_delta)
			: osw_pkg::ADJ_HOLD;
		res.right_adjust   = (check && lat_any) ? trim_of(delta_r, cfg.cruise_delta)
			: osw_pkg::ADJ_HOLD;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q   <= osw_pkg::COND_OK;
			period_q <= '0;
			mod3_q   <= '0;
			lat_l_q  <= '0;
			lat_r_q  <= '0;
		end else if (en) begin
			held_q   <= held_next;
			period_q <= period_next;
			mod3_q   <= mod3_next;
			lat_l_q  <= lat_l_next;
			lat_r_q  <= lat_r_next;
		end
	end

endmodule

// ----- design/osw_checker.sv -----
// port-level checks for obstacle_sense_and_wheel_trim, attached by bind
// depends on osw_pkg
module osw_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             tick_valid,
	input logic             tick_ready,
	input logic             result_valid,
	input logic             result_ready,
	input osw_pkg::result_t result_data
);

	// a stalled result stays put
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_data))
		else $error("result changed while stalled");

	// an empty result register never blocks the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> tick_ready)
		else $error("tick not ready with empty result register");

	a_right_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.avoid_command == osw_pkg::AVOID_RIGHT
		|-> result_data.path_condition == osw_pkg::COND_RIGHT)
		else $error("avoid right without right condition");

	a_ok_no_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.path_condition == osw_pkg::COND_OK
		|-> result_data.avoid_command == osw_pkg::AVOID_NONE)
		else $error("avoid command with clear path");

endmodule

bind obstacle_sense_and_wheel_trim osw_checker u_osw_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.tick_valid   (tick.valid),
	.tick_ready   (tick.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_data  (result.data)
);

// ----- dv/obstacle_sense_and_wheel_trim_tb.sv -----
// testbench for obstacle_sense_and_wheel_trim: directed and random control ticks against a predictor
// depends on osw_pkg and the channel interfaces in osw_if; drives the tick, result and cfg channels
module obstacle_sense_and_wheel_trim_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import osw_pkg::*;

	localparam int SAMPLE_MAX    = (1 << SAMPLE_BITS) - 1;
	localparam int PHASES        = 6;
	localparam int PHASE_TICKS   = 230;
	localparam int DIRECTED_TICKS = 24;
	localparam int SETTLE_CYCLES = 4;
	localparam int DRAIN_CYCLES  = 6;

	// receiver stall patterns
	localparam int RX_FREE   = 0;
	localparam int RX_RANDOM = 1;
	localparam int RX_RUNS   = 2;

	// predicts the result of every accepted tick and holds them in order
	class sense_trim_board;
		logic [THRESH_BITS-1:0]   thr;
		logic [DEBOUNCE_BITS-1:0] deb;
		logic [DELTA_BITS-1:0]    cruise;
		logic [LEVEL_BITS-1:0]    start_lvl;
		logic [SAMPLE_BITS-1:0]   prev_lvl [CHANNELS];
		logic [COUNT_BITS-1:0]    act_cnt [CHANNELS];
		cond_t                    held;
		logic [PERIOD_BITS-1:0]   period;
		logic [ENCODER_BITS-1:0]  latch [2];
		result_t                  outcome_q [$];
		int                       errors;
		int                       ticks_seen;
		int                       results_seen;
		int                       reg_writes;

		function new();
			thr = THRESHOLD_RST;
			deb = DEBOUNCE_RST;
			cruise = CRUISE_RST;
			start_lvl = START_RST;
			for (int i = 0; i < CHANNELS; i++) begin
				prev_lvl[i] = '0;
				act_cnt[i] = '0;
			end
			held = COND_OK;
			period = '0;
			latch[0] = '0;
			latch[1] = '0;
		endfunction

		function void set_reg(cfg_idx_t idx, logic [THRESH_BITS-1:0] v);
			reg_writes++;
			case (idx)
				CFG_CHANGE_THRESHOLD: thr = v;
				CFG_DEBOUNCE_COUNT:   deb = v[DEBOUNCE_BITS-1:0];
				CFG_CRUISE_DELTA:     cruise = v[DELTA_BITS-1:0];
				CFG_START_LEVEL:      start_lvl = v[LEVEL_BITS-1:0];
				default: ;
			endcase
		endfunction

		function adjust_t trim_for(logic [DELTA_BITS-1:0] delta);
			int d;
			d = int'(delta) - int'(cruise);
			if (d > DEAD_BAND)
				return ADJ_DEC;
			if (-d > DEAD_BAND)
				return ADJ_INC;
			return ADJ_HOLD;
		endfunction

		function void take_tick(tick_t t);
			logic [SAMPLE_BITS-1:0]  cur [CHANNELS];
			logic [SAMPLE_BITS-1:0]  diff;
			logic                    act [CHANNELS];
			logic                    hit_l;
			logic                    hit_r;
			logic [ENCODER_BITS-1:0] moved_l;
			logic [ENCODER_BITS-1:0] moved_r;
			result_t                 r;
			cur[CH_L]  = t.ir_left;
			cur[CH_CL] = t.ir_center_left;
			cur[CH_C]  = t.ir_center;
			cur[CH_CR] = t.ir_center_right;
			cur[CH_R]  = t.ir_right;
			for (int i = 0; i < CHANNELS; i++) begin
				diff = (cur[i] > prev_lvl[i]) ? cur[i] - prev_lvl[i] : prev_lvl[i] - cur[i];
				if (CMP_BITS'(diff) > CMP_BITS'(thr)) begin
					if (act_cnt[i] < {deb, 1'b0})
						act_cnt[i]++;
				end else if (act_cnt[i] != 0) begin
					act_cnt[i]--;
				end
				prev_lvl[i] = cur[i];
				act[i] = act_cnt[i] >= COUNT_BITS'(deb);
			end
			hit_l = !t.bumper_n[0];
			hit_r = !t.bumper_n[1];
			r = '0;
			r.avoid_command = AVOID_NONE;
			if (!t.avoid_busy) begin
				if (act[CH_R] && act[CH_L]) begin
					held = COND_BOTH;
					r.avoid_command = AVOID_LEFT;
				end else if (act[CH_L] || act[CH_CL] || hit_l) begin
					held = COND_LEFT;
					r.avoid_command = AVOID_LEFT;
				end else if (act[CH_R] || act[CH_CR] || hit_r) begin
					held = COND_RIGHT;
					r.avoid_command = AVOID_RIGHT;
				end else if (act[CH_C] || hit_l || hit_r) begin
					held = COND_HEAD;
					r.avoid_command = AVOID_LEFT;
				end else begin
					held = COND_OK;
				end
				// any avoidance restarts the speed measurement
				if (r.avoid_command != AVOID_NONE) begin
					latch[0] = '0;
					latch[1] = '0;
				end
			end
			r.path_condition = held;
			r.left_adjust = ADJ_HOLD;
			r.right_adjust = ADJ_HOLD;
			if (!t.trim_busy) begin
				r.left_start = (t.left_level == 0);
				r.right_start = (t.right_level == 0);
				period = period + 1'b1;
				if (period % 3 == 0) begin
					if (latch[0] != 0 || latch[1] != 0) begin
						moved_l = t.left_encoder - latch[0];
						moved_r = t.right_encoder - latch[1];
						r.left_adjust = trim_for(moved_l[DELTA_BITS-1:0]);
						r.right_adjust = trim_for(moved_r[DELTA_BITS-1:0]);
					end
					latch[0] = t.left_encoder;
					latch[1] = t.right_encoder;
				end
			end
			outcome_q.push_back(r);
			ticks_seen++;
		endfunction

		function void check_outcome(result_t got);
			result_t want;
			if (outcome_q.size() == 0) begin
				$error("result transaction with no tick pending: %h", got);
				errors++;
				return;
			end
			want = outcome_q.pop_front();
			results_seen++;
			if (got.path_condition !== want.path_condition) begin
				$error("path_condition: expected %0d, got %0d", want.path_condition,
					got.path_condition);
				errors++;
			end
			if (got.avoid_command !== want.avoid_command) begin
				$error("avoid_command: expected %0d, got %0d", want.avoid_command,
					got.avoid_command);
				errors++;
			end
			if (got.left_start !== want.left_start) begin
				$error("left_start: expected %0d, got %0d", want.left_start, got.left_start);
				errors++;
			end
			if (got.right_start !== want.right_start) begin
				$error("right_start: expected %0d, got %0d", want.right_start, got.right_start);
				errors++;
			end
			if (got.left_adjust !== want.left_adjust) begin
				$error("left_adjust: expected %0d, got %0d", want.left_adjust, got.left_adjust);
				errors++;
			end
			if (got.right_adjust !== want.right_adjust) begin
				$error("right_adjust: expected %0d, got %0d", want.right_adjust,
					got.right_adjust);
				errors++;
			end
		endfunction

		function int pending();
			return outcome_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	osw_tick_if   tick_ch ();
	osw_result_if res_ch ();
	osw_cfg_if    cfg_ch ();

	obstacle_sense_and_wheel_trim u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	sense_trim_board board = new();

	// stimulus generator state
	logic [SAMPLE_BITS-1:0]  gen_prev [CHANNELS];
	logic                    noisy [CHANNELS];
	logic [ENCODER_BITS-1:0] enc_run [2];
	int unsigned             gen_thr = THRESHOLD_RST;
	int unsigned             gen_cruise = CRUISE_RST;
	int unsigned             tx_burst_left = 0;
	bit                      tick_up = 1'b0;

	// receiver stall state
	int unsigned rx_mode = RX_FREE;
	int unsigned rx_mode_left = 0;
	int unsigned rx_run_left = 0;
	bit          rx_run_high = 1'b1;

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode = $urandom_range(RX_FREE, RX_RUNS);
			rx_mode_left = $urandom_range(40, 300);
		end
		rx_mode_left--;
		case (rx_mode)
			RX_FREE:   res_ch.ready <= 1'b1;
			RX_RANDOM: res_ch.ready <= ($urandom_range(0, 99) >= 35);
			default: begin
				if (rx_run_left == 0) begin
					rx_run_high = !rx_run_high;
					rx_run_left = rx_run_high ? $urandom_range(1, 8) : $urandom_range(1, 12);
				end
				rx_run_left--;
				res_ch.ready <= rx_run_high;
			end
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_ch.valid && cfg_ch.ready)
				board.set_reg(cfg_idx_t'(cfg_ch.index), cfg_ch.wdata);
			if (tick_ch.valid && tick_ch.ready)
				board.take_tick(tick_ch.data);
			if (res_ch.valid && res_ch.ready)
				board.check_outcome(res_ch.data);
		end
	end

	function logic [SAMPLE_BITS-1:0] next_level(int ch);
		int          v;
		int          mag;
		int unsigned pick;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return SAMPLE_BITS'(SAMPLE_MAX);
		if (noisy[ch] ? pick < 15 : pick < 4)
			return SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
		// jitter within the threshold keeps the counter falling
		mag = int'($urandom_range(0, gen_thr));
		if ($urandom_range(0, 1))
			v = int'(gen_prev[ch]) + mag;
		else
			v = int'(gen_prev[ch]) - mag;
		if (v < 0)
			v = 0;
		if (v > SAMPLE_MAX)
			v = SAMPLE_MAX;
		return SAMPLE_BITS'(v);
	endfunction

	function tick_t random_tick();
		tick_t                  t;
		logic [SAMPLE_BITS-1:0] s [CHANNELS];
		int unsigned            step_max;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			if ($urandom_range(0, 19) == 0)
				noisy[ch] = !noisy[ch];
			s[ch] = next_level(ch);
			gen_prev[ch] = s[ch];
		end
		// encoders advance about cruise_delta per three ticks
		step_max = (2 * gen_cruise + 6) / 3;
		for (int w = 0; w < 2; w++) begin
			if ($urandom_range(0, 49) == 0)
				enc_run[w] = $urandom();
			else
				enc_run[w] = enc_run[w] + $urandom_range(0, step_max);
		end
		t.ir_left = s[CH_L];
		t.ir_center_left = s[CH_CL];
		t.ir_center = s[CH_C];
		t.ir_center_right = s[CH_CR];
		t.ir_right = s[CH_R];
		t.bumper_n = ($urandom_range(0, 99) < 85) ? 2'b11 : 2'($urandom_range(0, 3));
		t.left_encoder = enc_run[0];
		t.right_encoder = enc_run[1];
		t.left_level = ($urandom_range(0, 4) == 0) ? '0 : LEVEL_BITS'($urandom_range(0, 31));
		t.right_level = ($urandom_range(0, 4) == 0) ? '0 : LEVEL_BITS'($urandom_range(0, 31));
		t.avoid_busy = ($urandom_range(0, 99) < 15);
		t.trim_busy = ($urandom_range(0, 99) < 15);
		return t;
	endfunction

	task automatic push_tick(input tick_t t);
		tick_ch.valid <= 1'b1;
		tick_ch.data <= t;
		tick_up = 1'b1;
		do @(posedge clk); while (!tick_ch.ready);
		if (tx_burst_left > 0) begin
			tx_burst_left--;
		end else begin
			tick_ch.valid <= 1'b0;
			tick_up = 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			// now and then a long stretch without gaps
			tx_burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 150)
				: $urandom_range(0, 12);
		end
	endtask

	task automatic lower_tick_valid();
		if (tick_up) begin
			tick_ch.valid <= 1'b0;
			tick_up = 1'b0;
		end
	endtask

	task automatic wait_drained();
		// let the monitor record the transaction of this edge first
		@(negedge clk);
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [THRESH_BITS-1:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.wdata <= v;
		do @(posedge clk); while (!cfg_ch.ready);
	endtask

	task automatic apply_setting(input int p);
		logic [THRESH_BITS-1:0]   thr;
		logic [DEBOUNCE_BITS-1:0] deb;
		logic [DELTA_BITS-1:0]    cru;
		logic [LEVEL_BITS-1:0]    lvl;
		thr = THRESH_BITS'($urandom_range(20, 400));
		deb = DEBOUNCE_BITS'($urandom_range(1, 7));
		cru = DELTA_BITS'($urandom_range(3, 60));
		lvl = LEVEL_BITS'($urandom_range(0, 31));
		case (p)
			0: begin thr = '0; deb = 3'd1; cru = '0; lvl = '0; end
			1: begin thr = '1; deb = 3'd7; cru = '1; lvl = '1; end
			// debounce of zero: every channel reads as active
			2: begin thr = 12'd150; deb = 3'd0; cru = 8'd10; lvl = 5'd15; end
			3: begin thr = 12'd60; deb = 3'd2; cru = 8'd9; lvl = 5'd5; end
			default: ;
		endcase
		write_reg(CFG_CHANGE_THRESHOLD, thr);
		write_reg(CFG_DEBOUNCE_COUNT, THRESH_BITS'(deb));
		write_reg(CFG_CRUISE_DELTA, THRESH_BITS'(cru));
		write_reg(CFG_START_LEVEL, THRESH_BITS'(lvl));
		cfg_ch.valid <= 1'b0;
		gen_thr = thr;
		gen_cruise = cru;
	endtask

	task automatic directed_ticks();
		tick_t t;
		for (int k = 0; k < DIRECTED_TICKS; k++) begin
			t = '0;
			// full-swing samples first, then a hold so the counters fall back, then single channels at zero
			if (k < 6) begin
				t.ir_left = (k % 2) ? SAMPLE_BITS'(SAMPLE_MAX) : '0;
				t.ir_center_left = t.ir_left;
				t.ir_center = t.ir_left;
				t.ir_center_right = t.ir_left;
				t.ir_right = t.ir_left;
			end else begin
				t.ir_left = SAMPLE_BITS'(SAMPLE_MAX);
				t.ir_center_left = SAMPLE_BITS'(SAMPLE_MAX);
				t.ir_center = SAMPLE_BITS'(SAMPLE_MAX);
				t.ir_center_right = SAMPLE_BITS'(SAMPLE_MAX);
				t.ir_right = SAMPLE_BITS'(SAMPLE_MAX);
				if (k >= 14) begin
					case ((k - 14) % CHANNELS)
						CH_L:    t.ir_left = '0;
						CH_CL:   t.ir_center_left = '0;
						CH_C:    t.ir_center = '0;
						CH_CR:   t.ir_center_right = '0;
						default: t.ir_right = '0;
					endcase
				end
			end
			t.bumper_n = (k >= 8 && k < 12) ? 2'(k) : 2'b11;
			t.left_encoder = (k < 16) ? ENCODER_BITS'(k * 7) : ENCODER_BITS'(32'hFFFF_FFF0 + k);
			t.right_encoder = ~t.left_encoder;
			t.left_level = (k % 3 == 0) ? '0 : (k % 3 == 1) ? '1 : LEVEL_BITS'(16);
			t.right_level = (k % 3 == 1) ? '0 : (k % 3 == 2) ? '1 : LEVEL_BITS'(16);
			t.avoid_busy = (k % 7 == 3);
			t.trim_busy = (k % 5 == 4);
			push_tick(t);
		end
	endtask

	initial begin
		tick_ch.valid = 1'b0;
		tick_ch.data = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_CHANGE_THRESHOLD;
		cfg_ch.wdata = '0;
		for (int ch = 0; ch < CHANNELS; ch++) begin
			gen_prev[ch] = '0;
			noisy[ch] = 1'b0;
		end
		enc_run[0] = $urandom();
		enc_run[1] = $urandom();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		directed_ticks();
		lower_tick_valid();
		for (int p = 0; p < PHASES; p++) begin
			wait_drained();
			repeat (SETTLE_CYCLES) @(posedge clk);
			apply_setting(p);
			for (int n = 0; n < PHASE_TICKS; n++)
				push_tick(random_tick());
			lower_tick_valid();
		end
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.pending() != 0) begin
			$error("%0d result transactions never arrived", board.pending());
			board.errors++;
		end

		$display("covered %0d ticks and %0d results over %0d register writes",
			board.ticks_seen, board.results_seen, board.reg_writes);
		if (board.errors == 0)
			$display("obstacle_sense_and_wheel_trim_tb: done, clean");
		else
			$display("obstacle_sense_and_wheel_trim_tb: done, errors");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("obstacle_sense_and_wheel_trim_tb: done, errors");
		$finish;
	end

endmodule

// ----- files.f -----
design/osw_pkg.sv
design/osw_if.sv
design/osw_ir_chan.sv
design/osw_ctrl.sv
design/obstacle_sense_and_wheel_trim.sv
design/osw_checker.sv
dv/obstacle_sense_and_wheel_trim_tb.sv
